// ----- hdl/ctt_pkg.sv -----
// shared constants and types for the currency text to cents converter
`timescale 1ns / 1ps
package ctt_pkg;

  localparam int MAG_W   = 63;
  localparam int CENTS_W = 64;

  // character codes the parser reacts to
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // finished amount handed from the parser to the result stages
  typedef struct packed {
    logic             err;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } ctt_total_t;

endpackage

// ----- hdl/ctt_in_if.sv -----
// input channel: one text byte or an end marker per beat
`timescale 1ns / 1ps
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ----- hdl/ctt_out_if.sv -----
// output channel: status and signed cents per beat
`timescale 1ns / 1ps
interface ctt_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [63:0] cents;

  modport source (output valid, output status, output cents, input ready);
  modport sink   (input valid, input status, input cents, output ready);
endinterface

// ----- hdl/ctt_parse.sv -----
// byte classifier and saturating decimal accumulator
`timescale 1ns / 1ps
module ctt_parse #(
  parameter int DIGIT_BUFFER_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          char_code,
  input  logic                end_of_text,
  output ctt_pkg::ctt_total_t total
);
  import ctt_pkg::*;

  localparam int CNT_W = $clog2(DIGIT_BUFFER_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGIT_BUFFER_BYTES - 1);

  logic [MAG_W-1:0] magnitude, magnitude_next;
  logic             saturated, saturated_next;
  logic             sign_negative, sign_negative_next;
  logic             digit_seen, digit_seen_next;
  logic             in_fraction, in_fraction_next;
  logic [1:0]       fraction_digits, fraction_digits_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  logic             error_latched, error_latched_next;

  logic [3:0]       digit;
  logic [MAG_W+3:0] acc_sum;
  logic             acc_ovf;
  logic [MAG_W-1:0] acc_mag;
  logic [MAG_W+6:0] scale_prod;
  logic             scale_ovf;

  // low nibble of an ascii digit is its value
  assign digit   = char_code[3:0];
  assign acc_sum = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0}
                 + {{MAG_W{1'b0}}, digit};
  assign acc_ovf = saturated || (acc_sum[MAG_W+3:MAG_W] != 4'd0);
  assign acc_mag = acc_ovf ? MAG_MAX : acc_sum[MAG_W-1:0];

  // pad missing fraction digits: times 100, times 10 or as is
  always_comb begin
    case (fraction_digits)
      2'd0: scale_prod = {1'b0, magnitude, 6'b000000} + {2'b00, magnitude, 5'b00000}
                       + {5'b00000, magnitude, 2'b00};
      2'd1: scale_prod = {4'b0000, magnitude, 3'b000} + {6'b000000, magnitude, 1'b0};
      default: scale_prod = {7'b0000000, magnitude};
    endcase
  end
  assign scale_ovf = scale_prod[MAG_W+6:MAG_W] != 7'd0;

  assign total.err = error_latched || !digit_seen;
  assign total.neg = sign_negative;
  assign total.mag = scale_ovf ? MAG_MAX : scale_prod[MAG_W-1:0];

  always_comb begin
    magnitude_next       = magnitude;
    saturated_next       = saturated;
    sign_negative_next   = sign_negative;
    digit_seen_next      = digit_seen;
    in_fraction_next     = in_fraction;
    fraction_digits_next = fraction_digits;
    digit_count_next     = digit_count;
    error_latched_next   = error_latched;
    if (take && end_of_text) begin
      magnitude_next       = '0;
      saturated_next       = 1'b0;
      sign_negative_next   = 1'b0;
      digit_seen_next      = 1'b0;
      in_fraction_next     = 1'b0;
      fraction_digits_next = 2'd0;
      digit_count_next     = '0;
      error_latched_next   = 1'b0;
    end else if (take && !error_latched) begin
      case (char_code) inside
        [CH_TAB:CH_CR], CH_SPACE, CH_DOLLAR, CH_COMMA, CH_RPAREN, CH_PLUS: begin
        end
        CH_LPAREN: sign_negative_next = 1'b1;
        CH_MINUS:  sign_negative_next = !sign_negative;
        CH_DOT: begin
          if (in_fraction) error_latched_next = 1'b1;
          else             in_fraction_next   = 1'b1;
        end
        [CH_0:CH_9]: begin
          if (digit_count >= CNT_LAST) begin
            error_latched_next = 1'b1;
          end else begin
            digit_count_next = digit_count + 1'b1;
            digit_seen_next  = 1'b1;
            if (in_fraction && fraction_digits >= 2'd2) begin
              error_latched_next = 1'b1;
            end else begin
              if (in_fraction) fraction_digits_next = fraction_digits + 2'd1;
              magnitude_next = acc_mag;
              saturated_next = acc_ovf;
            end
          end
        end
        default: error_latched_next = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude       <= '0;
      saturated       <= 1'b0;
      sign_negative   <= 1'b0;
      digit_seen      <= 1'b0;
      in_fraction     <= 1'b0;
      fraction_digits <= 2'd0;
      digit_count     <= '0;
      error_latched   <= 1'b0;
    end else begin
      magnitude       <= magnitude_next;
      saturated       <= saturated_next;
      sign_negative   <= sign_negative_next;
      digit_seen      <= digit_seen_next;
      in_fraction     <= in_fraction_next;
      fraction_digits <= fraction_digits_next;
      digit_count     <= digit_count_next;
      error_latched   <= error_latched_next;
    end
  end

endmodule

// ----- hdl/currency_text_to_cents.sv -----
// top level of the currency text to cents converter
`timescale 1ns / 1ps
// Converts a money amount given as ascii text, one byte per input beat, into a
// signed 64-bit count of cents. A beat with end_of_text set closes the amount
// and yields exactly one output beat: status 0 with the cents value, or status 1
// (cents zero) for malformed text. Whitespace, '$', ',', ')' and '+' are
// skipped, '(' makes the amount negative, '-' flips the sign, one '.' opens a
// fraction of at most two digits. At most DIGIT_BUFFER_BYTES-1 digits are
// taken; the magnitude saturates at 2^63-1. Any byte that is not part of this
// set marks the amount as malformed and later bytes are ignored until the end.
// Rate: one input beat per clock while the result registers have room. The
// limit is the accumulator loop, a multiply by ten (two shifted adds) plus the
// digit, fed back into the magnitude register on each digit. A result is scaled
// to cents on the way into a holding register, then signed on the way into the
// output register. The two registers let text keep flowing while the output
// side stalls, until the holding register is full as well.
module currency_text_to_cents #(
  parameter int DIGIT_BUFFER_BYTES = 64
) (
  input logic     clk,
  input logic     rst,
  ctt_in_if.sink  text_in,
  ctt_out_if.source cents_out
);
  import ctt_pkg::*;

  // holding stage for a finished amount
  ctt_total_t total;
  ctt_total_t fin;
  logic       fin_valid;

  // output register
  logic               out_valid;
  logic               out_status;
  logic [CENTS_W-1:0] out_amount;

  logic               in_beat;
  logic               fin_load;
  logic               out_load;
  logic [CENTS_W-1:0] mag_ext;

  // output register free, or being emptied this cycle
  assign out_load = fin_valid && (!out_valid || cents_out.ready);
  // the holding stage can take a new amount when empty or moving on
  assign text_in.ready = !fin_valid || out_load;
  assign in_beat  = text_in.valid && text_in.ready;
  assign fin_load = in_beat && text_in.end_of_text;

  ctt_parse #(
    .DIGIT_BUFFER_BYTES(DIGIT_BUFFER_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .take        (in_beat),
    .char_code   (text_in.char_code),
    .end_of_text (text_in.end_of_text),
    .total       (total)
  );

  // holding register, payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_load) begin
      fin_valid <= 1'b1;
    end else if (out_load) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin <= total;
    end
  end

  // sign applied on the way into the output register
  assign mag_ext = {1'b0, fin.mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (cents_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= fin.err;
      if (fin.err)      out_amount <= '0;
      else if (fin.neg) out_amount <= ~mag_ext + {{(CENTS_W-1){1'b0}}, 1'b1};
      else              out_amount <= mag_ext;
    end
  end

  assign cents_out.valid  = out_valid;
  assign cents_out.status = out_status;
  assign cents_out.cents  = out_amount;

  // a malformed amount always reports zero cents
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    cents_out.valid && cents_out.status |-> cents_out.cents == 64'sd0)
    else $error("malformed amount with nonzero cents");

  // saturation keeps results symmetric, the most negative value never appears
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    cents_out.valid |-> cents_out.cents != 64'sh8000_0000_0000_0000)
    else $error("cents reached the most negative value");

  // a finished amount is never overwritten before it moves on
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !out_load |-> !fin_load)
    else $error("holding stage overwritten");

  // an end-marker beat always fills the holding stage on the next edge
  a_fin_fill: assert property (@(posedge clk) disable iff (rst)
    fin_load |=> fin_valid)
    else $error("end marker lost");

endmodule

// ----- sim/currency_text_to_cents_tb.sv -----
// testbench for the currency text to cents converter: drives amount text, predicts and checks cents
`timescale 1ns / 1ps
module currency_text_to_cents_tb;
  import ctt_pkg::*;

  localparam int DIGIT_LIMIT = 64;

  typedef logic [7:0] text_t [$];

  typedef struct packed {
    logic                      status;
    logic signed [CENTS_W-1:0] cents;
  } cents_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ctt_in_if  text_in ();
  ctt_out_if cents_out ();

  currency_text_to_cents #(
    .DIGIT_BUFFER_BYTES(DIGIT_LIMIT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .cents_out(cents_out)
  );

  always #4 clk = ~clk;

  // amounts predicted but not yet seen on the output
  cents_beat_t expected_amounts[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          long_hold_req = 0;
  int          hold_left = 0;
  int          beats_sent = 0;

  // parser state of the predictor
  logic [MAG_W-1:0] acc_mag;
  logic             acc_sat;
  logic             acc_neg;
  logic             acc_seen;
  logic             acc_frac;
  logic             acc_err;
  int unsigned      acc_frac_digits;
  int unsigned      acc_digits;

  function automatic void clear_amount();
    acc_mag         = '0;
    acc_sat         = 1'b0;
    acc_neg         = 1'b0;
    acc_seen        = 1'b0;
    acc_frac        = 1'b0;
    acc_err         = 1'b0;
    acc_frac_digits = 0;
    acc_digits      = 0;
  endfunction

  // magnitude times ten plus digit, sticking at the top once it overflows
  function automatic void add_digit(input int unsigned d);
    logic [CENTS_W-1:0] headroom;
    headroom = ({1'b0, MAG_MAX} - CENTS_W'(d)) / 10;
    if (acc_sat || {1'b0, acc_mag} > headroom) begin
      acc_sat = 1'b1;
      acc_mag = MAG_MAX;
    end else begin
      acc_mag = acc_mag * 10 + MAG_W'(d);
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    if (acc_err) return;
    if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == CH_DOLLAR ||
        c == CH_COMMA || c == CH_RPAREN || c == CH_PLUS) return;
    if (c == CH_LPAREN) begin
      acc_neg = 1'b1;
      return;
    end
    if (c == CH_MINUS) begin
      acc_neg = ~acc_neg;
      return;
    end
    if (c == CH_DOT) begin
      if (acc_frac) acc_err = 1'b1;
      else acc_frac = 1'b1;
      return;
    end
    if (c < CH_0 || c > CH_9) begin
      acc_err = 1'b1;
      return;
    end
    if (acc_digits + 1 >= DIGIT_LIMIT) begin
      acc_err = 1'b1;
      return;
    end
    acc_digits++;
    acc_seen = 1'b1;
    if (acc_frac) begin
      if (acc_frac_digits >= 2) begin
        acc_err = 1'b1;
        return;
      end
      acc_frac_digits++;
    end
    add_digit(int'(c - CH_0));
  endfunction

  // end marker: scale to cents and apply the sign, or report malformed text, then start afresh
  function automatic cents_beat_t close_amount();
    cents_beat_t        r;
    logic [CENTS_W-1:0] value;
    if (acc_err || !acc_seen) begin
      r.status = 1'b1;
      r.cents  = '0;
    end else begin
      for (int unsigned k = acc_frac_digits; k < 2; k++) add_digit(0);
      value = {1'b0, acc_mag};
      if (acc_neg) value = -value;
      r.status = 1'b0;
      r.cents  = value;
    end
    clear_amount();
    return r;
  endfunction

  // one input beat; the expectation is updated at the accepting edge
  task automatic send_beat(input logic [7:0] ch, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      text_in.valid       = 1'b0;
      text_in.char_code   = 8'($urandom);
      text_in.end_of_text = 1'($urandom);
      @(negedge clk);
    end
    text_in.valid       = 1'b1;
    text_in.char_code   = ch;
    text_in.end_of_text = eot;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
    if (eot) expected_amounts.push_back(close_amount());
    else parse_byte(ch);
    beats_sent++;
    @(negedge clk);
    text_in.valid = 1'b0;
  endtask

  // text bytes followed by an end marker whose byte is don't-care
  task automatic send_amount(input text_t txt);
    foreach (txt[i]) send_beat(txt[i], 1'b0);
    send_beat(8'($urandom), 1'b1);
  endtask

  function automatic text_t text_of(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic text_t digits_of(input int n, input logic [7:0] ch);
    text_t t;
    repeat (n) t.push_back(ch);
    return t;
  endfunction

  // mostly well-formed amounts with random content, some of them broken
  function automatic text_t random_amount();
    text_t t;
    int    r;
    int    n_int;
    int    n_frac;
    repeat ($urandom_range(2)) begin
      case ($urandom_range(6))
        0: t.push_back(CH_TAB + 8'($urandom_range(4)));
        1: t.push_back(CH_SPACE);
        2: t.push_back(CH_DOLLAR);
        3: t.push_back(CH_PLUS);
        4: t.push_back(CH_LPAREN);
        default: t.push_back(CH_MINUS);
      endcase
    end
    r = $urandom_range(99);
    if (r < 80) n_int = $urandom_range(7);
    else if (r < 95) n_int = $urandom_range(19, 14);
    else n_int = $urandom_range(DIGIT_LIMIT, DIGIT_LIMIT - 6);
    for (int i = 0; i < n_int; i++) begin
      t.push_back(CH_0 + 8'($urandom_range(9)));
      if ($urandom_range(7) == 0) t.push_back(CH_COMMA);
    end
    if ($urandom_range(1)) begin
      t.push_back(CH_DOT);
      n_frac = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
      repeat (n_frac) t.push_back(CH_0 + 8'($urandom_range(9)));
    end
    case ($urandom_range(3))
      0: t.push_back(CH_RPAREN);
      1: t.push_back(CH_SPACE);
      default: ;
    endcase
    r = $urandom_range(99);
    if (r < 6) t.insert($urandom_range(t.size()), 8'($urandom));
    else if (r < 10) t.insert($urandom_range(t.size()), CH_DOT);
    else if (r < 14) repeat ($urandom_range(1, 4)) t.push_back(8'($urandom));
    return t;
  endfunction

  // signs, separators, fraction rules and the error cases on short text
  task automatic test_directed_amounts();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_amount(text_of("(1.2)"));
    send_amount(text_of("-$9,0.99"));
    send_amount(text_of("+\t3"));
    send_amount(text_of("(-7"));
    send_amount(text_of("1.2."));
    send_amount(text_of("1.234"));
    send_amount(text_of(""));
    send_amount('{8'h00, CH_0 + 8'd5});
    send_amount('{8'hFF});
    send_amount('{CH_0, 8'h0A, 8'h0B, 8'h0C, CH_CR});
  endtask

  // saturation at the top of the range and the cap on digits taken
  task automatic test_long_amounts();
    text_t t;
    send_amount(text_of("92233720368547758.07"));
    send_amount(text_of("-92233720368547758.08"));
    send_amount(digits_of(DIGIT_LIMIT - 1, CH_9));
    t = digits_of(DIGIT_LIMIT - 1, CH_9);
    t.push_front(CH_LPAREN);
    send_amount(t);
    send_amount(digits_of(DIGIT_LIMIT, CH_0 + 8'd1));
    t = digits_of(DIGIT_LIMIT - 2, CH_0);
    t.push_back(CH_DOT);
    t.push_back(CH_0 + 8'd1);
    t.push_back(CH_0 + 8'd2);
    send_amount(t);
  endtask

  task automatic test_random_amounts(input int n_beats, input int idle_pct, input int stall_pct);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = beats_sent;
    while (beats_sent - start < n_beats) send_amount(random_amount());
  endtask

  // receiver holds off for a long stretch so the result stages fill and text stalls
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req  = 150;
    repeat (10) send_amount(text_of("$12.5"));
    repeat (4) send_amount(random_amount());
  endtask

  // result side ready, with random stalls and the occasional long hold-off
  always @(negedge clk) begin
    if (long_hold_req > 0) begin
      hold_left     = long_hold_req;
      long_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      cents_out.ready <= 1'b0;
    end else begin
      cents_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cents_beat_t want;
    if (!rst && cents_out.valid === 1'b1 && cents_out.ready === 1'b1) begin
      if (expected_amounts.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected: status=%0b cents=%0d",
                 $time, cents_out.status, cents_out.cents);
      end else begin
        want = expected_amounts.pop_front();
        if (cents_out.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0b actual %0b", $time, want.status,
                   cents_out.status);
        end
        if (cents_out.cents !== want.cents) begin
          mismatches++;
          $display("%0t: cents expected %0d actual %0d", $time, want.cents,
                   cents_out.cents);
        end
      end
    end
  end

  initial begin
    text_in.valid       = 1'b0;
    text_in.char_code   = 8'h00;
    text_in.end_of_text = 1'b0;
    cents_out.ready     = 1'b0;
    clear_amount();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_amounts();
    test_long_amounts();
    test_random_amounts(200, 0, 0);
    test_random_amounts(200, 47, 0);
    test_random_amounts(200, 0, 47);
    test_random_amounts(200, 20, 20);
    test_output_backpressure();

    recv_stall_pct = 0;
    wait (expected_amounts.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_amounts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
